[src/tkcl_pkg.sv]
// ----------------------------------------------------------------------------
// tkcl_pkg: shared types and codes for the top-k candidate list
// Beat payloads, the stored entry, per-cell control and the status codes.
// ----------------------------------------------------------------------------
package tkcl_pkg;

   localparam int TKCL_DEPTH = 16;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_DUMP = 1'b1;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_EVICTED  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_DROPPED  = 3'd3;
   localparam logic [2:0] ST_DUMP_ENT = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   // cell operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_EVICT  = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [31:0] cand_frequency;
      logic [31:0] cand_time;
      logic [31:0] cand_magnitude;
      logic [15:0] cand_probability;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_frequency;
      logic [31:0] out_time;
      logic [31:0] out_magnitude;
      logic [15:0] out_probability;
      logic [4:0]  held_count;
      logic        last;
   } rsp_payload_type;

   // key order: magnitude, then time, then frequency (MSB first)
   typedef struct packed {
      logic [31:0] ent_magnitude;
      logic [31:0] ent_time;
      logic [31:0] ent_frequency;
      logic [15:0] ent_probability;
   } entry_type;

   typedef struct packed {
      logic       cmp_en;
      logic       valid;
      logic       tail;
      logic [1:0] op;
   } cell_ctl_type;

endpackage

[src/top_k_candidate_list_core.sv]
// ----------------------------------------------------------------------------
// top_k_candidate_list_core: sorted top-k list of detection candidates
// Push inserts, refuses duplicates, or evicts or drops the smallest; dump reads out.
// ----------------------------------------------------------------------------
// Push: compare is registered at accept; shift and result beat follow in
//   S_PUSH once the result side is free; no new request is taken till then.
// Dump: one beat per held entry, one beat per cycle while the result side
//   keeps up, as the chain rotates one slot per beat; empty gives one beat.
// Reset (synchronous) clears the count, FSM and output valid; limit -> 16.
// ----------------------------------------------------------------------------
module top_k_candidate_list_core #(
   parameter int DEPTH = tkcl_pkg::TKCL_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tkcl_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tkcl_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [4:0]               csr_data
);

   // count width holds 0..DEPTH; limit compare width covers 5-bit register too
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > 5) ? CW : 5;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PUSH = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] dump_left_ff, dump_left_in;
   logic [4:0]  limit_ff, limit_in;
   tkcl_pkg::entry_type cand_ff, cand_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tkcl_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // chain wiring
   tkcl_pkg::entry_type  cell_entry [DEPTH];
   logic [DEPTH-1:0]     cell_lt, cell_eq;
   tkcl_pkg::cell_ctl_type cell_ctl [DEPTH];
   tkcl_pkg::entry_type  key_cand;

   logic          accept, out_free, load;
   logic [1:0]    chain_op;
   logic [LW-1:0] lim_raw, lim_eff;
   logic [LW:0]   count_next_ext;
   logic          over_limit, dup;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   assign key_cand = '{ent_magnitude:   req_data.cand_magnitude,
                       ent_time:        req_data.cand_time,
                       ent_frequency:   req_data.cand_frequency,
                       ent_probability: req_data.cand_probability};

   // effective limit: 0 acts as 1, anything past DEPTH acts as DEPTH
   assign lim_raw = LW'(limit_ff);
   always_comb begin
      lim_eff = lim_raw;
      if (lim_raw == '0) lim_eff = LW'(1);
      else if (lim_raw > LW'(DEPTH)) lim_eff = LW'(DEPTH);
   end

   assign count_next_ext = (LW + 1)'(count_ff) + (LW + 1)'(1);
   assign over_limit     = count_next_ext > (LW + 1)'(lim_eff);
   assign dup            = |cell_eq;

   // ---- chain of cells ----
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic                left_lt_w, right_lt_w;
         tkcl_pkg::entry_type left_w, right_w;

         // slot 0 sees "everything to its left is lower"; last slot sees none above
         if (gi == 0) begin : g_head
            assign left_lt_w = 1'b1;
            assign left_w    = cand_ff;
         end else begin : g_mid_l
            assign left_lt_w = cell_lt[gi-1];
            assign left_w    = cell_entry[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign right_lt_w = 1'b0;
            assign right_w    = cell_entry[0];
         end else begin : g_mid_r
            assign right_lt_w = cell_lt[gi+1];
            assign right_w    = cell_entry[gi+1];
         end

         assign cell_ctl[gi] = '{cmp_en: accept,
                                 valid:  (count_ff > CW'(gi)),
                                 tail:   (count_ff == CW'(gi + 1)),
                                 op:     chain_op};

         tkcl_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl[gi]),
            .key_cand    (key_cand),
            .ins_cand    (cand_ff),
            .left_lt     (left_lt_w),
            .left_entry  (left_w),
            .right_lt    (right_lt_w),
            .right_entry (right_w),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[gi]),
            .lt          (cell_lt[gi]),
            .eq          (cell_eq[gi])
         );
      end
   endgenerate

   // ---- control ----
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      limit_in     = limit_ff;
      cand_in      = cand_ff;
      chain_op     = tkcl_pkg::OP_HOLD;
      load         = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid & csr_ready) limit_in = csr_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cand_in      = key_cand;
               dump_left_in = count_ff;
               state_in     = (req_data.cmd == tkcl_pkg::CMD_DUMP) ? S_DUMP : S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               load        = 1'b1;
               state_in    = S_IDLE;
               rsp_data_in = '0;
               rsp_data_in.last = 1'b1;
               if (dup) begin
                  rsp_data_in.status = tkcl_pkg::ST_DUPLICATE;
               end else if (over_limit) begin
                  if (!cell_lt[0]) begin
                     // new candidate is the smallest: report it back
                     rsp_data_in.status          = tkcl_pkg::ST_DROPPED;
                     rsp_data_in.out_frequency   = cand_ff.ent_frequency;
                     rsp_data_in.out_time        = cand_ff.ent_time;
                     rsp_data_in.out_magnitude   = cand_ff.ent_magnitude;
                     rsp_data_in.out_probability = cand_ff.ent_probability;
                  end else begin
                     chain_op                    = tkcl_pkg::OP_EVICT;
                     rsp_data_in.status          = tkcl_pkg::ST_EVICTED;
                     rsp_data_in.out_frequency   = cell_entry[0].ent_frequency;
                     rsp_data_in.out_time        = cell_entry[0].ent_time;
                     rsp_data_in.out_magnitude   = cell_entry[0].ent_magnitude;
                     rsp_data_in.out_probability = cell_entry[0].ent_probability;
                  end
               end else begin
                  chain_op           = tkcl_pkg::OP_INSERT;
                  count_in           = count_ff + CW'(1);
                  rsp_data_in.status = tkcl_pkg::ST_INSERTED;
               end
               rsp_data_in.held_count = 5'(count_in);
            end
         end
         S_DUMP: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.held_count = 5'(count_ff);
               if (count_ff == '0) begin
                  rsp_data_in.status = tkcl_pkg::ST_EMPTY;
                  rsp_data_in.last   = 1'b1;
                  state_in           = S_IDLE;
               end else begin
                  // head slot goes out, chain rotates so order is restored at the end
                  chain_op                    = tkcl_pkg::OP_ROTATE;
                  rsp_data_in.status          = tkcl_pkg::ST_DUMP_ENT;
                  rsp_data_in.out_frequency   = cell_entry[0].ent_frequency;
                  rsp_data_in.out_time        = cell_entry[0].ent_time;
                  rsp_data_in.out_magnitude   = cell_entry[0].ent_magnitude;
                  rsp_data_in.out_probability = cell_entry[0].ent_probability;
                  rsp_data_in.last            = (dump_left_ff == CW'(1));
                  dump_left_in                = dump_left_ff - CW'(1);
                  if (dump_left_ff == CW'(1)) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = load ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         limit_ff     <= 5'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/tkcl_cell.sv]
// ----------------------------------------------------------------------------
// tkcl_cell: one slot of the sorted candidate chain
// Holds one entry, compares it against a new key, and shifts with neighbors.
// ----------------------------------------------------------------------------
module tkcl_cell (
   input  logic                  clock,
   input  tkcl_pkg::cell_ctl_type ctl,
   input  tkcl_pkg::entry_type   key_cand,
   input  tkcl_pkg::entry_type   ins_cand,
   input  logic                  left_lt,
   input  tkcl_pkg::entry_type   left_entry,
   input  logic                  right_lt,
   input  tkcl_pkg::entry_type   right_entry,
   input  tkcl_pkg::entry_type   head_entry,
   output tkcl_pkg::entry_type   entry,
   output logic                  lt,
   output logic                  eq
);

   tkcl_pkg::entry_type entry_ff, entry_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;
   logic [95:0]         own_key, new_key;

   assign own_key = {entry_ff.ent_magnitude, entry_ff.ent_time, entry_ff.ent_frequency};
   assign new_key = {key_cand.ent_magnitude, key_cand.ent_time, key_cand.ent_frequency};

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = ctl.valid & (own_key < new_key);
         eq_in = ctl.valid & (own_key == new_key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         tkcl_pkg::OP_HOLD: entry_in = entry_ff;
         tkcl_pkg::OP_INSERT: begin
            // lower entries stay, first non-lower slot takes the new one, higher ones shift up
            if (!lt_ff) entry_in = left_lt ? ins_cand : left_entry;
         end
         tkcl_pkg::OP_EVICT: begin
            // drop slot 0, close the gap below the insertion point
            if (right_lt) entry_in = right_entry;
            else if (lt_ff) entry_in = ins_cand;
         end
         tkcl_pkg::OP_ROTATE: entry_in = ctl.tail ? head_entry : right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-k candidate list core
// Drives push and dump beats with random idling on both sides, mirrors the
// sorted list in a local predictor and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int QUIET_LIMIT = 4000;   // cycles with no accepted beat
   localparam int HOLD_OFF    = 150;    // long receiver stall for fill-up

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   tkcl_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   tkcl_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [4:0]                csr_data;

   // mirror of the list held by the block
   tkcl_pkg::entry_type       mirror_entry [tkcl_pkg::TKCL_DEPTH];
   int                        mirror_count = 0;
   logic [4:0]                mirror_limit = 5'd16;
   tkcl_pkg::rsp_payload_type predicted_rsp [$];

   bit sender_idles    = 1'b1;
   bit receiver_idles  = 1'b1;
   int hold_off_cycles = 0;
   int fail_count      = 0;
   int quiet_cycles    = 0;

   top_k_candidate_list_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // sort key: magnitude, then time, then frequency; probability rides along
   function automatic logic [95:0] key_of(tkcl_pkg::entry_type e);
      return {e.ent_magnitude, e.ent_time, e.ent_frequency};
   endfunction

   function automatic tkcl_pkg::rsp_payload_type with_entry(tkcl_pkg::rsp_payload_type r,
                                                            tkcl_pkg::entry_type e);
      r.out_frequency   = e.ent_frequency;
      r.out_time        = e.ent_time;
      r.out_magnitude   = e.ent_magnitude;
      r.out_probability = e.ent_probability;
      return r;
   endfunction

   function automatic void predict_list_update(tkcl_pkg::req_payload_type b);
      tkcl_pkg::rsp_payload_type r;
      tkcl_pkg::entry_type       cand;
      tkcl_pkg::entry_type       gone;
      logic [95:0]               ck;
      int                        lim;
      int                        pos;
      int                        i;
      r      = '0;
      r.last = 1'b1;
      lim    = mirror_limit;
      if (lim < 1) lim = 1;
      if (lim > tkcl_pkg::TKCL_DEPTH) lim = tkcl_pkg::TKCL_DEPTH;
      cand.ent_magnitude   = b.cand_magnitude;
      cand.ent_time        = b.cand_time;
      cand.ent_frequency   = b.cand_frequency;
      cand.ent_probability = b.cand_probability;
      ck = key_of(cand);

      if (b.cmd == tkcl_pkg::CMD_DUMP) begin
         if (mirror_count == 0) begin
            r.status = tkcl_pkg::ST_EMPTY;
            predicted_rsp.insert(predicted_rsp.size(), r);
            return;
         end
         for (i = 0; i < mirror_count; i++) begin
            r            = with_entry(r, mirror_entry[i]);
            r.status     = tkcl_pkg::ST_DUMP_ENT;
            r.held_count = 5'(mirror_count);
            r.last       = (i == mirror_count - 1);
            predicted_rsp.insert(predicted_rsp.size(), r);
         end
         return;
      end

      pos = 0;
      for (i = 0; i < mirror_count; i++) begin
         if (key_of(mirror_entry[i]) == ck) begin
            // same three keys: refused, held probability kept
            r.status     = tkcl_pkg::ST_DUPLICATE;
            r.held_count = 5'(mirror_count);
            predicted_rsp.insert(predicted_rsp.size(), r);
            return;
         end
         if (key_of(mirror_entry[i]) < ck) pos = i + 1;
      end

      if (mirror_count + 1 > lim) begin
         if (pos == 0) begin
            // candidate itself is the smallest
            r        = with_entry(r, cand);
            r.status = tkcl_pkg::ST_DROPPED;
         end else begin
            gone = mirror_entry[0];
            for (i = 0; i + 1 < pos; i++) mirror_entry[i] = mirror_entry[i + 1];
            mirror_entry[pos - 1] = cand;
            r        = with_entry(r, gone);
            r.status = tkcl_pkg::ST_EVICTED;
         end
      end else begin
         for (i = mirror_count; i > pos; i--) mirror_entry[i] = mirror_entry[i - 1];
         mirror_entry[pos] = cand;
         mirror_count++;
         r.status = tkcl_pkg::ST_INSERTED;
      end
      r.held_count = 5'(mirror_count);
      predicted_rsp.insert(predicted_rsp.size(), r);
   endfunction

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      tkcl_pkg::rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_rsp.size() == 0) begin
            $display("%0t: result beat with none expected, expected none, actual %h",
                     $time, rsp_data);
            fail_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("out_frequency", want.out_frequency, rsp_data.out_frequency);
            check_field("out_time", want.out_time, rsp_data.out_time);
            check_field("out_magnitude", want.out_magnitude, rsp_data.out_magnitude);
            check_field("out_probability", want.out_probability, rsp_data.out_probability);
            check_field("held_count", want.held_count, rsp_data.held_count);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall per beat, plus an optional long hold-off
   // ------------------------------------------------------------------------
   initial begin : rsp_drain
      int wait_cycles;
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         wait_cycles = receiver_idles ? $urandom_range(0, 5) : 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // watchdog: a stretch with no accepted beat on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // valid stays high after the accepting edge; the next call lowers it only
   // when it draws a gap
   task automatic send_beat(input logic cmd, input logic [31:0] mag, input logic [31:0] tim,
                            input logic [31:0] frq, input logic [15:0] prob);
      tkcl_pkg::req_payload_type b;
      int                        gap;
      b.cmd              = cmd;
      b.cand_magnitude   = mag;
      b.cand_time        = tim;
      b.cand_frequency   = frq;
      b.cand_probability = prob;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_list_update(b);
   endtask

   task automatic push_cand(input logic [31:0] mag, input logic [31:0] tim,
                            input logic [31:0] frq, input logic [15:0] prob);
      send_beat(tkcl_pkg::CMD_PUSH, mag, tim, frq, prob);
   endtask

   // payload fields of a dump are don't-care: fill them at random
   task automatic dump_list();
      send_beat(tkcl_pkg::CMD_DUMP, $urandom(), $urandom(), $urandom(), 16'($urandom()));
   endtask

   // limit is only changed with the list idle and every result drained
   task automatic write_limit(input logic [4:0] value);
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mirror_limit = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // small pool and extremes so ties and duplicates come up often
   function automatic logic [31:0] draw_key();
      case ($urandom_range(0, 9))
         0:          return 32'h0000_0000;
         1:          return 32'hFFFF_FFFF;
         2, 3, 4, 5: return $urandom_range(0, 3);
         default:    return $urandom();
      endcase
   endfunction

   task automatic send_random_item();
      if ($urandom_range(0, 19) == 0) dump_list();
      else push_cand(draw_key(), draw_key(), draw_key(), 16'($urandom()));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // extremes, duplicate refusal, tie-breaks, eviction and drop
   task automatic test_directed_ops();
      write_limit(5'd2);
      dump_list();                                                 // empty list
      push_cand(32'h0, 32'h0, 32'h0, 16'h0000);
      push_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      push_cand(32'h0, 32'h0, 32'h0, 16'h1234);                    // duplicate keys
      push_cand(32'd5, 32'd7, 32'd1, 16'h00A5);                    // evicts smallest
      push_cand(32'd5, 32'd7, 32'd0, 16'h5A00);                    // new one dropped
      push_cand(32'd5, 32'd7, 32'd2, 16'h8001);                    // frequency tie-break
      dump_list();
      write_limit(5'd0);                                           // acts as one
      push_cand(32'd5, 32'd8, 32'd0, 16'h7FFF);
      push_cand(32'd5, 32'd6, 32'd9, 16'h0001);
      dump_list();
      write_limit(5'd31);                                          // clamps to depth
      push_cand(32'd5, 32'd6, 32'd9, 16'h0002);
      push_cand(32'd5, 32'd7, 32'd0, 16'h0003);
      push_cand(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFE);
      push_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 16'h8000);
      push_cand(32'h0, 32'h0, 32'hFFFF_FFFF, 16'h4000);
      dump_list();
   endtask

   // random phases over several limits and idling patterns
   task automatic test_random_phases();
      logic [4:0] lim;
      int         phase;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       lim = 5'd16;
            1:       lim = 5'd3;
            2:       lim = 5'd31;
            3:       lim = 5'($urandom_range(1, 15));
            default: lim = 5'd0;
         endcase
         sender_idles   = (phase != 1);
         receiver_idles = (phase != 1) && (phase != 2);
         write_limit(lim);
         repeat (50) send_random_item();
         dump_list();
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // receiver holds off while pushes keep coming: the core must stall input
   task automatic test_input_backpressure();
      write_limit(5'd16);
      sender_idles    = 1'b0;
      hold_off_cycles = HOLD_OFF;
      repeat (40) push_cand(draw_key(), draw_key(), draw_key(), 16'($urandom()));
      dump_list();
      sender_idles = 1'b1;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_random_phases();
      test_input_backpressure();

      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[top_k_candidate_list_core.f]
src/tkcl_pkg.sv
src/tkcl_cell.sv
src/top_k_candidate_list_core.sv
bench/tb_top.sv
